### rtl/core/huffman_bit_packer_core_assert.svh
// Assertion macros for the packer core.
`ifndef HUFFMAN_BIT_PACKER_CORE_ASSERT_SVH
`define HUFFMAN_BIT_PACKER_CORE_ASSERT_SVH

// Checked at every clock edge, reset included.
`define HBP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

// Checked only out of reset.
`define HBP_ASSERT_RUN(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

`endif

### rtl/core/hbp_pkg.sv
package hbp_pkg;

  localparam int SYMBOL_W  = 8;
  localparam int CODE_W    = 32;
  localparam int SIZE_W    = 6;
  localparam int PACKED_W  = 16;
  localparam int TOTAL_W   = 32;
  localparam int OUT_DEPTH = 4;

  typedef enum logic [1:0] {
    CMD_LOAD   = 2'd0,
    CMD_ENCODE = 2'd1,
    CMD_FLUSH  = 2'd2
  } cmd_e;

  typedef struct packed {
    logic [PACKED_W-1:0] packed_word;
    logic [TOTAL_W-1:0]  total_bits;
    logic                is_flush;
    logic                last_of_run;
  } result_t;

endpackage

### rtl/core/hbp_code_mem.sv
module hbp_code_mem #(
  parameter int NUM_SYMBOLS   = 256,
  parameter int MAX_CODE_BITS = 32
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 wr_en_i,
  input  logic [$clog2(NUM_SYMBOLS)-1:0]       wr_addr_i,
  input  logic [MAX_CODE_BITS-1:0]             wr_code_i,
  input  logic [$clog2(MAX_CODE_BITS+1)-1:0]   wr_len_i,
  input  logic                                 rd_en_i,
  input  logic [$clog2(NUM_SYMBOLS)-1:0]       rd_addr_i,
  output logic [MAX_CODE_BITS-1:0]             rd_code_o,
  output logic [$clog2(MAX_CODE_BITS+1)-1:0]   rd_len_o
);

  localparam int LenW = $clog2(MAX_CODE_BITS + 1);

  logic [MAX_CODE_BITS-1:0] code_mem [NUM_SYMBOLS];
  logic [LenW-1:0]          len_mem  [NUM_SYMBOLS];
  logic [NUM_SYMBOLS-1:0]   valid_q;
  logic [MAX_CODE_BITS-1:0] rd_code_q;
  logic [LenW-1:0]          rd_len_q;
  logic                     rd_hit_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      code_mem[wr_addr_i] <= wr_code_i;
      len_mem[wr_addr_i]  <= wr_len_i;
    end
    if (rd_en_i) begin
      rd_code_q <= code_mem[rd_addr_i];
      rd_len_q  <= len_mem[rd_addr_i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= '0;
      rd_hit_q <= 1'b0;
    end else begin
      if (wr_en_i) begin
        valid_q[wr_addr_i] <= 1'b1;
      end
      if (rd_en_i) begin
        rd_hit_q <= valid_q[rd_addr_i];
      end
    end
  end

  // never-loaded entries read as zero
  assign rd_code_o = rd_hit_q ? rd_code_q : '0;
  assign rd_len_o  = rd_hit_q ? rd_len_q  : '0;

endmodule

### rtl/core/hbp_packer.sv
module hbp_packer #(
  parameter int MAX_CODE_BITS = 32,
  parameter int WORD_BITS     = 16
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               fire_i,
  input  hbp_pkg::cmd_e                      cmd_i,
  input  logic [MAX_CODE_BITS-1:0]           code_i,
  input  logic [$clog2(MAX_CODE_BITS+1)-1:0] len_i,
  output logic [1:0]                         push_cnt_o,
  output hbp_pkg::result_t                   res0_o,
  output hbp_pkg::result_t                   res1_o
);

  import hbp_pkg::*;

  localparam int LenW     = $clog2(MAX_CODE_BITS + 1);
  localparam int FillW    = $clog2(WORD_BITS);
  localparam int AccW     = WORD_BITS + MAX_CODE_BITS;
  localparam int NbW      = $clog2(AccW);
  localparam int MaxWords = (AccW - 1) / WORD_BITS;

  logic [WORD_BITS-1:0]     pend_q, pend_d;
  logic [FillW-1:0]         fill_q, fill_d;
  logic [TOTAL_W-1:0]       total_q, total_d;

  logic [MAX_CODE_BITS-1:0] code_m;
  logic [AccW-1:0]          acc, acc_hi, rem_acc;
  logic [NbW-1:0]           nbits, rem_bits;
  logic [2:0]               words;
  logic [31:0]              w0_ext, w1_ext, pend_ext;

  always_comb begin
    for (int i = 0; i < MAX_CODE_BITS; i++) begin
      code_m[i] = code_i[i] & (i < int'(len_i));
    end
    acc    = AccW'(pend_q) | (AccW'(code_m) << fill_q);
    nbits  = NbW'(fill_q) + NbW'(len_i);
    acc_hi = acc >> WORD_BITS;
    words    = '0;
    rem_acc  = acc;
    rem_bits = nbits;
    for (int j = 1; j <= MaxWords; j++) begin
      if (nbits >= NbW'(j * WORD_BITS)) begin
        words    = 3'(j);
        rem_acc  = acc >> (j * WORD_BITS);
        rem_bits = nbits - NbW'(j * WORD_BITS);
      end
    end
    w0_ext   = 32'(acc[WORD_BITS-1:0]);
    w1_ext   = 32'(acc_hi[WORD_BITS-1:0]);
    pend_ext = 32'(pend_q);
  end

  always_comb begin
    push_cnt_o = 2'd0;
    res0_o     = '{packed_word: w0_ext[PACKED_W-1:0], total_bits: '0,
                   is_flush: 1'b0, last_of_run: (words == 3'd1)};
    res1_o     = '{packed_word: w1_ext[PACKED_W-1:0], total_bits: '0,
                   is_flush: 1'b0, last_of_run: 1'b1};
    pend_d     = pend_q;
    fill_d     = fill_q;
    total_d    = total_q;
    case (cmd_i)
      CMD_ENCODE: begin
        if (len_i != '0) begin
          push_cnt_o = (words >= 3'd2) ? 2'd2 : words[1:0];
          pend_d     = rem_acc[WORD_BITS-1:0];
          fill_d     = rem_bits[FillW-1:0];
          total_d    = total_q + TOTAL_W'(len_i);
        end
      end
      CMD_FLUSH: begin
        push_cnt_o = 2'd1;
        res0_o     = '{packed_word: pend_ext[PACKED_W-1:0], total_bits: total_q,
                       is_flush: 1'b1, last_of_run: 1'b1};
        pend_d     = '0;
        fill_d     = '0;
        total_d    = '0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q  <= '0;
      fill_q  <= '0;
      total_q <= '0;
    end else if (fire_i) begin
      pend_q  <= pend_d;
      fill_q  <= fill_d;
      total_q <= total_d;
    end
  end

endmodule

### rtl/core/hbp_out_fifo.sv
module hbp_out_fifo (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [1:0]       push_cnt_i,
  input  hbp_pkg::result_t res0_i,
  input  hbp_pkg::result_t res1_i,
  input  logic             pop_i,
  output logic             room_o,
  output logic             valid_o,
  output hbp_pkg::result_t head_o
);

  import hbp_pkg::*;

  localparam int PtrW = $clog2(OUT_DEPTH);
  localparam int CntW = $clog2(OUT_DEPTH + 1);

  result_t         buf_q [OUT_DEPTH];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q, wr_ptr_p1;
  logic [CntW-1:0] count_q, count_d;

  assign wr_ptr_p1 = wr_ptr_q + PtrW'(1);
  assign count_d   = count_q + CntW'(push_cnt_i) - CntW'(pop_i);
  assign room_o    = (count_q <= CntW'(OUT_DEPTH - 2));
  assign valid_o   = (count_q != '0);
  assign head_o    = buf_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_cnt_i != 2'd0) begin
      buf_q[wr_ptr_q] <= res0_i;
    end
    if (push_cnt_i == 2'd2) begin
      buf_q[wr_ptr_p1] <= res1_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_q + PtrW'(push_cnt_i);
      rd_ptr_q <= rd_ptr_q + PtrW'(pop_i);
      count_q  <= count_d;
    end
  end

endmodule

### rtl/core/huffman_bit_packer_core.sv
// Table-driven Huffman encoder with a 16-bit word packer.
// Input channel (in_valid_i/in_ready_o) takes one command item per cycle:
//   load writes a symbol's code and length, encode appends the symbol's
//   code LSB first, flush emits the partial word with the message bit count.
// Output channel (out_valid_o/out_ready_i) returns result items; an encode
//   yields zero, one or two words, a flush exactly one, a load none.
// Path: an item is registered with its table read, then packed into a
//   four-entry result queue from which it is offered.
// Throughput: one item per cycle while the queue holds two or fewer
//   results; the output port drains one result per cycle, so runs of
//   two-word encodes are paced by the output side.
// Reset: every table entry reads as zero length (per-entry valid bits are
//   cleared at once), the packer and the queue are emptied; no clearing pass.
// A stalled receiver fills the queue; the pack stage then holds its item
//   and in_ready_o drops until room frees up. Nothing is lost or repeated.
`include "huffman_bit_packer_core_assert.svh"

module huffman_bit_packer_core #(
  parameter int NUM_SYMBOLS   = 256,
  parameter int MAX_CODE_BITS = 32,
  parameter int WORD_BITS     = 16
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [1:0]                     command_i,
  input  logic [hbp_pkg::SYMBOL_W-1:0]   symbol_i,
  input  logic [hbp_pkg::CODE_W-1:0]     code_word_i,
  input  logic [hbp_pkg::SIZE_W-1:0]     code_size_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [hbp_pkg::PACKED_W-1:0]   packed_word_o,
  output logic [hbp_pkg::TOTAL_W-1:0]    total_bits_o,
  output logic                           is_flush_o,
  output logic                           last_of_run_o
);

  import hbp_pkg::*;

  localparam int SymW = $clog2(NUM_SYMBOLS);
  localparam int LenW = $clog2(MAX_CODE_BITS + 1);

  cmd_e                     in_cmd;
  logic                     in_acc, in_range;
  logic [LenW-1:0]          size_sat;
  logic                     s1_valid_q, s1_range_q, s1_fire;
  cmd_e                     s1_cmd_q;
  logic [MAX_CODE_BITS-1:0] rd_code;
  logic [LenW-1:0]          rd_len, s1_len;
  logic                     room;
  logic [1:0]               push_cnt;
  result_t                  res0, res1, head;

  assign in_cmd   = cmd_e'(command_i);
  assign in_acc   = in_valid_i && in_ready_o;
  assign in_range = ({1'b0, symbol_i} < (SYMBOL_W + 1)'(NUM_SYMBOLS));
  assign size_sat = (code_size_i > SIZE_W'(MAX_CODE_BITS)) ?
                    LenW'(MAX_CODE_BITS) : LenW'(code_size_i);

  assign s1_fire    = s1_valid_q && room;
  assign in_ready_o = !s1_valid_q || s1_fire;
  assign s1_len     = s1_range_q ? rd_len : '0;

  hbp_code_mem #(
    .NUM_SYMBOLS  (NUM_SYMBOLS),
    .MAX_CODE_BITS(MAX_CODE_BITS)
  ) u_mem (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .wr_en_i  (in_acc && (in_cmd == CMD_LOAD) && in_range),
    .wr_addr_i(symbol_i[SymW-1:0]),
    .wr_code_i(code_word_i[MAX_CODE_BITS-1:0]),
    .wr_len_i (size_sat),
    .rd_en_i  (in_acc),
    .rd_addr_i(symbol_i[SymW-1:0]),
    .rd_code_o(rd_code),
    .rd_len_o (rd_len)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_cmd_q   <= in_cmd;
      s1_range_q <= in_range;
    end
  end

  hbp_packer #(
    .MAX_CODE_BITS(MAX_CODE_BITS),
    .WORD_BITS    (WORD_BITS)
  ) u_packer (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .fire_i    (s1_fire),
    .cmd_i     (s1_cmd_q),
    .code_i    (rd_code),
    .len_i     (s1_len),
    .push_cnt_o(push_cnt),
    .res0_o    (res0),
    .res1_o    (res1)
  );

  hbp_out_fifo u_fifo (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_cnt_i(s1_fire ? push_cnt : 2'd0),
    .res0_i    (res0),
    .res1_i    (res1),
    .pop_i     (out_valid_o && out_ready_i),
    .room_o    (room),
    .valid_o   (out_valid_o),
    .head_o    (head)
  );

  assign packed_word_o = head.packed_word;
  assign total_bits_o  = head.total_bits;
  assign is_flush_o    = head.is_flush;
  assign last_of_run_o = head.last_of_run;

  `HBP_ASSERT(a_ready_free, !in_ready_o |-> s1_valid_q, "input stalled with empty pack stage")
  `HBP_ASSERT_RUN(a_stage_hold, s1_valid_q && !s1_fire |=> s1_valid_q, "pack stage dropped item")
  `HBP_ASSERT_RUN(a_flush_last, out_valid_o && is_flush_o |-> last_of_run_o, "flush not last")
  `HBP_ASSERT_RUN(a_word_total, out_valid_o && !is_flush_o |-> total_bits_o == '0, "word total set")

endmodule

### test/huffman_bit_packer_core_tb.sv
module huffman_bit_packer_core_tb;
  import hbp_pkg::*;

  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam int HOLD_CYCLES = 300;

  typedef struct {
    logic [1:0]  cmd;
    logic [7:0]  sym;
    logic [31:0] cw;
    logic [5:0]  cs;
  } cmd_item_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [1:0]  command_i = 2'd0;
  logic [7:0]  symbol_i = 8'd0;
  logic [31:0] code_word_i = 32'd0;
  logic [5:0]  code_size_i = 6'd0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [15:0] packed_word_o;
  logic [31:0] total_bits_o;
  logic        is_flush_o;
  logic        last_of_run_o;

  huffman_bit_packer_core dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .command_i     (command_i),
    .symbol_i      (symbol_i),
    .code_word_i   (code_word_i),
    .code_size_i   (code_size_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .packed_word_o (packed_word_o),
    .total_bits_o  (total_bits_o),
    .is_flush_o    (is_flush_o),
    .last_of_run_o (last_of_run_o)
  );

  always #10 clk_i = ~clk_i;

  cmd_item_t cmd_q[$];
  cmd_item_t drv_item;
  result_t   words_due[$];
  result_t   want;

  // packer model state
  logic [31:0] code_mem [256];
  logic [5:0]  size_mem [256];
  logic [15:0] acc_word;
  logic [3:0]  acc_fill;
  logic [31:0] msg_bits;

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  logic hold_req = 1'b0;
  logic out_hold = 1'b0;

  int mismatches = 0;
  int items_taken = 0;
  int results_checked = 0;
  int input_stalls = 0;

  task automatic flag_mismatch(input string what, input logic [31:0] got,
                               input logic [31:0] want_val);
    mismatches++;
    $display("MISMATCH %s: got %h, want %h (result %0d)", what, got, want_val,
             results_checked);
  endtask

  task automatic pack_item(input logic [1:0] cmd, input logic [7:0] sym,
                           input logic [31:0] cw, input logic [5:0] cs);
    int len;
    int nbits;
    int nwords;
    logic [63:0] code;
    logic [63:0] acc;
    result_t r;
    case (cmd)
      CMD_LOAD: begin
        code_mem[sym] = cw;
        size_mem[sym] = (cs > 6'd32) ? 6'd32 : cs;
      end
      CMD_ENCODE: begin
        len = size_mem[sym];
        if (len != 0) begin
          code = {32'd0, code_mem[sym]} & ((64'd1 << len) - 64'd1);
          acc = {48'd0, acc_word} | (code << acc_fill);
          nbits = acc_fill + len;
          nwords = nbits / 16;
          for (int k = 0; k < nwords; k++) begin
            r.packed_word = acc[16*k +: 16];
            r.total_bits = 32'd0;
            r.is_flush = 1'b0;
            r.last_of_run = (k == nwords - 1);
            words_due.push_back(r);
          end
          acc_word = acc[16*nwords +: 16];
          acc_fill = 4'(nbits % 16);
          msg_bits = msg_bits + 32'(len);
        end
      end
      CMD_FLUSH: begin
        r.packed_word = acc_word;
        r.total_bits = msg_bits;
        r.is_flush = 1'b1;
        r.last_of_run = 1'b1;
        words_due.push_back(r);
        acc_word = 16'd0;
        acc_fill = 4'd0;
        msg_bits = 32'd0;
      end
      default: ;
    endcase
  endtask

  // driver
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else if (!in_valid_i || in_ready_o) begin
      if (cmd_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        drv_item = cmd_q.pop_front();
        in_valid_i  <= 1'b1;
        command_i   <= drv_item.cmd;
        symbol_i    <= drv_item.sym;
        code_word_i <= drv_item.cw;
        code_size_i <= drv_item.cs;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // receiver
  always @(posedge clk_i) begin
    out_ready_i <= !out_hold && ($urandom_range(99) >= recv_stall_pct);
  end

  // long output hold to fill the result queue
  initial begin
    wait (hold_req);
    @(posedge clk_i);
    out_hold <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk_i);
    out_hold <= 1'b0;
  end

  // monitor and checker
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        if (words_due.size() == 0) begin
          flag_mismatch("unexpected result word", {16'd0, packed_word_o}, 32'd0);
        end else begin
          want = words_due.pop_front();
          if (packed_word_o !== want.packed_word)
            flag_mismatch("packed_word", {16'd0, packed_word_o}, {16'd0, want.packed_word});
          if (total_bits_o !== want.total_bits)
            flag_mismatch("total_bits", total_bits_o, want.total_bits);
          if (is_flush_o !== want.is_flush)
            flag_mismatch("is_flush", {31'd0, is_flush_o}, {31'd0, want.is_flush});
          if (last_of_run_o !== want.last_of_run)
            flag_mismatch("last_of_run", {31'd0, last_of_run_o}, {31'd0, want.last_of_run});
          results_checked++;
        end
      end
      if (in_valid_i && !in_ready_o)
        input_stalls++;
      if (in_valid_i && in_ready_o) begin
        pack_item(command_i, symbol_i, code_word_i, code_size_i);
        items_taken++;
      end
    end
  end

  task automatic push_item(input logic [1:0] cmd, input logic [7:0] sym,
                           input logic [31:0] cw, input logic [5:0] cs);
    cmd_item_t it;
    it.cmd = cmd;
    it.sym = sym;
    it.cw = cw;
    it.cs = cs;
    cmd_q.push_back(it);
  endtask

  function automatic logic [5:0] pick_size();
    int r;
    r = $urandom_range(99);
    if (r < 8) return 6'd0;
    if (r < 70) return 6'($urandom_range(12, 1));
    if (r < 92) return 6'($urandom_range(32, 13));
    return 6'($urandom_range(63, 33));
  endfunction

  // one message: a block of table loads, a run of commands (mostly encodes), usually a flush
  task automatic queue_message(input int n_enc);
    logic [7:0] base;
    int span;
    int r;
    base = 8'($urandom_range(255));
    span = $urandom_range(12, 3);
    for (int i = 0; i < span; i++)
      push_item(CMD_LOAD, 8'(base + i), $urandom(), pick_size());
    for (int i = 0; i < n_enc; i++) begin
      r = $urandom_range(99);
      if (r < 85)
        push_item(CMD_ENCODE, 8'(base + $urandom_range(span - 1)), $urandom(),
                  6'($urandom_range(63)));
      else if (r < 93)
        push_item(CMD_ENCODE, 8'($urandom_range(255)), $urandom(), 6'($urandom_range(63)));
      else if (r < 97)
        push_item(CMD_LOAD, 8'(base + $urandom_range(span - 1)), $urandom(), pick_size());
      else
        push_item(CMD_UNUSED, 8'($urandom_range(255)), $urandom(), 6'($urandom_range(63)));
    end
    if ($urandom_range(9) != 0)
      push_item(CMD_FLUSH, 8'($urandom_range(255)), $urandom(), 6'($urandom_range(63)));
  endtask

  task automatic queue_random(input int target);
    while (cmd_q.size() < target)
      queue_message($urandom_range(40, 5));
  endtask

  task automatic drain();
    while (cmd_q.size() != 0 || in_valid_i || words_due.size() != 0)
      @(negedge clk_i);
    // loads give no result; let the two-stage pipe settle
    repeat (6) @(negedge clk_i);
  endtask

  task automatic set_pace(input int idle_pct, input int stall_pct);
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
  endtask

  initial begin
    for (int i = 0; i < 256; i++) begin
      code_mem[i] = 32'd0;
      size_mem[i] = 6'd0;
    end
    acc_word = 16'd0;
    acc_fill = 4'd0;
    msg_bits = 32'd0;

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed
    set_pace(0, 0);
    push_item(CMD_FLUSH, 8'd0, 32'd0, 6'd0);
    push_item(CMD_ENCODE, 8'd0, 32'd0, 6'd0);
    push_item(CMD_LOAD, 8'd0, 32'hFFFF_FFFF, 6'd32);
    push_item(CMD_LOAD, 8'd255, 32'hA5A5_5A5A, 6'd63);
    push_item(CMD_LOAD, 8'd1, 32'h0000_0001, 6'd1);
    push_item(CMD_LOAD, 8'd2, 32'hFFFF_7FFE, 6'd15);
    push_item(CMD_LOAD, 8'd3, 32'hDEAD_BEEF, 6'd0);
    push_item(CMD_LOAD, 8'd4, 32'h1234_ABCD, 6'd16);
    push_item(CMD_LOAD, 8'd5, 32'h8000_0003, 6'd33);
    push_item(CMD_ENCODE, 8'd1, 32'd0, 6'd0);
    push_item(CMD_ENCODE, 8'd0, 32'hFFFF_FFFF, 6'd63);
    push_item(CMD_ENCODE, 8'd255, 32'd0, 6'd0);
    push_item(CMD_ENCODE, 8'd3, 32'd0, 6'd0);
    push_item(CMD_ENCODE, 8'd2, 32'd0, 6'd0);
    push_item(CMD_ENCODE, 8'd4, 32'd0, 6'd0);
    push_item(CMD_UNUSED, 8'd255, 32'hFFFF_FFFF, 6'd63);
    push_item(CMD_ENCODE, 8'd5, 32'd0, 6'd0);
    push_item(CMD_FLUSH, 8'd0, 32'd0, 6'd0);
    push_item(CMD_FLUSH, 8'd255, 32'hFFFF_FFFF, 6'd63);
    push_item(CMD_ENCODE, 8'd4, 32'd0, 6'd0);
    push_item(CMD_ENCODE, 8'd4, 32'd0, 6'd0);
    push_item(CMD_FLUSH, 8'd0, 32'd0, 6'd0);
    drain();

    queue_random(250);
    drain();

    set_pace(88, 0);
    queue_random(250);
    drain();

    set_pace(0, 88);
    queue_random(250);
    drain();

    set_pace(8, 8);
    queue_random(250);
    drain();

    set_pace(0, 0);
    hold_req = 1'b1;
    queue_random(250);
    drain();

    $display("Covered %0d accepted items (loads, encodes, flushes, unused commands),",
             items_taken);
    $display("%0d result items checked over five pacing phases; input stalled %0d cycles.",
             results_checked, input_stalls);
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("Timeout: %0d items still queued, %0d results outstanding",
             cmd_q.size(), words_due.size());
    $display("Some tests failed");
    $finish;
  end

endmodule

### sim.f
+incdir+rtl/core
rtl/core/hbp_pkg.sv
rtl/core/hbp_code_mem.sv
rtl/core/hbp_packer.sv
rtl/core/hbp_out_fifo.sv
rtl/core/huffman_bit_packer_core.sv
test/huffman_bit_packer_core_tb.sv
